// File: rtl/core/sdf_pkg.sv
// sdf_pkg: shared types, constants and helper functions of the signed decimal formatter
// no dependencies; compile before every other file of the block

package sdf_pkg;

    localparam int VALUE_W   = 32;
    localparam int FW_W      = 6;
    localparam int PREC_W    = 6;
    localparam int CHAR_W    = 7;
    localparam int DIGITS    = 10;
    localparam int DIGIT_W   = 4;
    localparam int BCD_W     = DIGITS * DIGIT_W;
    localparam int NDIG_W    = 4;
    localparam int BIT_CNT_W = $clog2(VALUE_W);
    localparam int CALC_W    = 8;

    localparam logic [CHAR_W-1:0] CHAR_NUL   = 7'h00;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 7'h20;
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 7'h2B;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;

    typedef struct packed {
        logic [FW_W-1:0]          field_width;
        logic signed [PREC_W-1:0] precision;
        logic                     left_justify;
        logic                     zero_pad;
        logic                     force_plus;
        logic                     space_sign;
    } sdf_fmt_t;

    typedef struct packed {
        logic [BCD_W-1:0]  bcd;
        logic [NDIG_W-1:0] ndig;
        logic              neg;
        sdf_fmt_t          fmt;
    } sdf_conv_t;

    typedef enum logic [1:0] {
        CV_IDLE,
        CV_SHIFT,
        CV_NORM,
        CV_DONE
    } sdf_cv_state_t;

    typedef enum logic [1:0] {
        EM_IDLE,
        EM_RUN,
        EM_EMPTY
    } sdf_em_state_t;

    // add 3 to every digit of 5 or more ahead of the next left shift
    function automatic logic [BCD_W-1:0] bcd_adjust(input logic [BCD_W-1:0] bcd);
        logic [BCD_W-1:0]   res;
        logic [DIGIT_W-1:0] d;
        res = bcd;
        for (int i = 0; i < DIGITS; i++)
        begin
            d = bcd[i*DIGIT_W +: DIGIT_W];
            if (d >= DIGIT_W'(5))
            begin
                res[i*DIGIT_W +: DIGIT_W] = d + DIGIT_W'(3);
            end
        end
        return res;
    endfunction

    // every digit in 0..9
    function automatic logic bcd_valid(input logic [BCD_W-1:0] bcd);
        logic ok;
        ok = 1'b1;
        for (int i = 0; i < DIGITS; i++)
        begin
            if (bcd[i*DIGIT_W +: DIGIT_W] > DIGIT_W'(9))
            begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

endpackage

// File: rtl/core/sdf_channels.sv
// sdf_in_if / sdf_out_if: valid/ready channels of the signed decimal formatter
// depends on sdf_pkg for field widths

interface sdf_in_if;
    import sdf_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [VALUE_W-1:0] value;
    logic [FW_W-1:0]          field_width;
    logic signed [PREC_W-1:0] precision;
    logic                     left_justify;
    logic                     zero_pad;
    logic                     force_plus;
    logic                     space_sign;

    modport source (
        output valid, value, field_width, precision,
               left_justify, zero_pad, force_plus, space_sign,
        input  ready
    );

    modport sink (
        input  valid, value, field_width, precision,
               left_justify, zero_pad, force_plus, space_sign,
        output ready
    );
endinterface

interface sdf_out_if;
    import sdf_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] character;
    logic              is_last;
    logic              empty_res;

    modport source (
        output valid, character, is_last, empty_res,
        input  ready
    );

    modport sink (
        input  valid, character, is_last, empty_res,
        output ready
    );
endinterface

// File: rtl/core/sdf_bcd_conv.sv
// sdf_bcd_conv: bit-serial binary to bcd conversion (shift-add-3) of the magnitude
// depends on sdf_pkg and sdf_in_if

module sdf_bcd_conv (
    input  logic              clk,
    input  logic              rst_n,
    sdf_in_if.sink            in_ch,
    output sdf_pkg::sdf_conv_t conv,
    output logic              conv_valid,
    input  logic              conv_take
);
    import sdf_pkg::*;

    sdf_cv_state_t          state_reg, state_next;
    logic [BIT_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [VALUE_W-1:0]     bin_reg, bin_next;
    logic [BCD_W-1:0]       bcd_reg, bcd_next;
    logic [NDIG_W-1:0]      ndig_reg, ndig_next;
    logic                   neg_reg, neg_next;
    sdf_fmt_t               fmt_reg, fmt_next;

    logic [VALUE_W-1:0]     raw;
    logic [VALUE_W-1:0]     mag;
    logic [BCD_W-1:0]       adj;
    logic                   top_zero;
    logic                   shrink;
    logic                   in_fire;

    assign raw      = in_ch.value;
    assign mag      = raw[VALUE_W-1] ? (~raw + VALUE_W'(1)) : raw;
    assign adj      = bcd_adjust(bcd_reg);
    assign top_zero = (bcd_reg[BCD_W-1 -: DIGIT_W] == '0);
    assign shrink   = top_zero && (ndig_reg > NDIG_W'(1));
    assign in_fire  = in_ch.valid && in_ch.ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            CV_IDLE:
            begin
                if (in_ch.valid)
                begin
                    state_next = CV_SHIFT;
                end
            end
            CV_SHIFT:
            begin
                if (cnt_reg == BIT_CNT_W'(VALUE_W - 1))
                begin
                    state_next = CV_NORM;
                end
            end
            CV_NORM:
            begin
                if (!shrink)
                begin
                    state_next = CV_DONE;
                end
            end
            CV_DONE:
            begin
                if (conv_take)
                begin
                    state_next = CV_IDLE;
                end
            end
            default: state_next = CV_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        in_ch.ready = (state_reg == CV_IDLE);
        conv_valid  = (state_reg == CV_DONE);
    end

    // datapath
    always_comb
    begin
        cnt_next  = cnt_reg;
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        ndig_next = ndig_reg;
        neg_next  = neg_reg;
        fmt_next  = fmt_reg;
        unique case (state_reg)
            CV_IDLE:
            begin
                if (in_ch.valid)
                begin
                    cnt_next  = '0;
                    bin_next  = mag;
                    bcd_next  = '0;
                    neg_next  = raw[VALUE_W-1];
                    fmt_next.field_width  = in_ch.field_width;
                    fmt_next.precision    = in_ch.precision;
                    fmt_next.left_justify = in_ch.left_justify;
                    fmt_next.zero_pad     = in_ch.zero_pad;
                    fmt_next.force_plus   = in_ch.force_plus;
                    fmt_next.space_sign   = in_ch.space_sign;
                end
            end
            CV_SHIFT:
            begin
                bcd_next  = {adj[BCD_W-2:0], bin_reg[VALUE_W-1]};
                bin_next  = {bin_reg[VALUE_W-2:0], 1'b0};
                cnt_next  = cnt_reg + BIT_CNT_W'(1);
                ndig_next = NDIG_W'(DIGITS);
            end
            CV_NORM:
            begin
                // drop leading zero digits, one per cycle, keep at least one
                if (shrink)
                begin
                    bcd_next  = {bcd_reg[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
                    ndig_next = ndig_reg - NDIG_W'(1);
                end
            end
            CV_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CV_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg  <= bin_next;
        bcd_reg  <= bcd_next;
        ndig_reg <= ndig_next;
        neg_reg  <= neg_next;
        fmt_reg  <= fmt_next;
    end

    assign conv.bcd  = bcd_reg;
    assign conv.ndig = ndig_reg;
    assign conv.neg  = neg_reg;
    assign conv.fmt  = fmt_reg;

    a_bcd_digits: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == CV_SHIFT |-> bcd_valid(bcd_reg))
        else $error("bcd digit out of range during conversion");

    a_ndig_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == CV_DONE |-> (ndig_reg >= NDIG_W'(1) && ndig_reg <= NDIG_W'(DIGITS)))
        else $error("digit count out of range");

    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == CV_SHIFT && cnt_reg == '0))
        else $error("conversion did not start after item");

endmodule

// File: rtl/core/sdf_emitter.sv
// sdf_emitter: lays out padding, sign, zeros and digits and sends one character per cycle
// unless the output stalls; depends on sdf_pkg and sdf_out_if

module sdf_emitter #(
    parameter int MAX_WIDTH     = 32,
    parameter int MAX_PRECISION = 30
) (
    input  logic               clk,
    input  logic               rst_n,
    input  sdf_pkg::sdf_conv_t conv,
    input  logic               conv_valid,
    output logic               conv_take,
    sdf_out_if.source          out_ch
);
    import sdf_pkg::*;

    localparam int MAX_LEN = (MAX_WIDTH > MAX_PRECISION + 1) ? MAX_WIDTH : MAX_PRECISION + 1;
    localparam int CNT_W   = $clog2(MAX_LEN + 1);

    sdf_em_state_t       state_reg, state_next;
    logic [CNT_W-1:0]    pos_reg, pos_next;
    logic [CNT_W-1:0]    b1_reg, b2_reg, b3_reg, b4_reg, total_reg;
    logic [CHAR_W-1:0]   sign_reg;
    logic [BCD_W-1:0]    dig_reg, dig_next;
    logic                out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]   out_char_reg;
    logic                out_last_reg;
    logic                out_empty_reg;

    // layout of the incoming item
    logic [CALC_W-1:0]   fw_ext, width_c, prec_ext, prec_c, nd_c, nsign_c;
    logic [CALC_W-1:0]   len_c, zeros_c, body_c, spaces_c;
    logic [CALC_W-1:0]   b1_c, b2_c, b3_c, b4_c, total_c;
    logic                has_prec, mag_zero;
    logic [CHAR_W-1:0]   sign_c;

    logic                adv;
    logic                out_load;
    logic                in_digits;
    logic                last_c;
    logic [CHAR_W-1:0]   char_c;

    always_comb
    begin
        fw_ext   = CALC_W'(conv.fmt.field_width);
        width_c  = (fw_ext > CALC_W'(MAX_WIDTH)) ? CALC_W'(MAX_WIDTH) : fw_ext;
        has_prec = !conv.fmt.precision[PREC_W-1];
        prec_ext = CALC_W'(conv.fmt.precision[PREC_W-2:0]);
        if (!has_prec)
        begin
            prec_c = '0;
        end
        else if (prec_ext > CALC_W'(MAX_PRECISION))
        begin
            prec_c = CALC_W'(MAX_PRECISION);
        end
        else
        begin
            prec_c = prec_ext;
        end
        mag_zero = (conv.ndig == NDIG_W'(1)) && (conv.bcd[BCD_W-1 -: DIGIT_W] == '0);
        // zero value with zero precision prints no digits
        nd_c = (has_prec && prec_c == '0 && mag_zero) ? '0 : CALC_W'(conv.ndig);

        priority if (conv.neg)
        begin
            sign_c = CHAR_MINUS;
        end
        else if (conv.fmt.force_plus)
        begin
            sign_c = CHAR_PLUS;
        end
        else if (conv.fmt.space_sign)
        begin
            sign_c = CHAR_SPACE;
        end
        else
        begin
            sign_c = CHAR_NUL;
        end
        nsign_c = CALC_W'(sign_c != CHAR_NUL);
        len_c   = nd_c + nsign_c;

        zeros_c = '0;
        if (has_prec && prec_c > nd_c)
        begin
            zeros_c = prec_c - nd_c;
        end
        if (!has_prec && !conv.fmt.left_justify && conv.fmt.zero_pad && width_c > len_c)
        begin
            zeros_c = width_c - len_c;
        end
        body_c   = len_c + zeros_c;
        spaces_c = (width_c > body_c) ? (width_c - body_c) : '0;

        b1_c    = conv.fmt.left_justify ? '0 : spaces_c;
        b2_c    = b1_c + nsign_c;
        b3_c    = b2_c + zeros_c;
        b4_c    = b3_c + nd_c;
        total_c = b4_c + (conv.fmt.left_justify ? spaces_c : '0);
    end

    assign adv = !out_valid_reg || out_ch.ready;

    // character at the current position
    always_comb
    begin
        in_digits = 1'b0;
        priority if (pos_reg < b1_reg)
        begin
            char_c = CHAR_SPACE;
        end
        else if (pos_reg < b2_reg)
        begin
            char_c = sign_reg;
        end
        else if (pos_reg < b3_reg)
        begin
            char_c = CHAR_ZERO;
        end
        else if (pos_reg < b4_reg)
        begin
            char_c    = CHAR_ZERO + CHAR_W'(dig_reg[BCD_W-1 -: DIGIT_W]);
            in_digits = 1'b1;
        end
        else
        begin
            char_c = CHAR_SPACE;
        end
        last_c = (pos_reg == total_reg - CNT_W'(1));
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            EM_IDLE:
            begin
                if (conv_valid)
                begin
                    state_next = (total_c == '0) ? EM_EMPTY : EM_RUN;
                end
            end
            EM_RUN:
            begin
                if (adv && last_c)
                begin
                    state_next = EM_IDLE;
                end
            end
            EM_EMPTY:
            begin
                if (adv)
                begin
                    state_next = EM_IDLE;
                end
            end
            default: state_next = EM_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        conv_take = (state_reg == EM_IDLE) && conv_valid;
        out_load  = adv && (state_reg == EM_RUN || state_reg == EM_EMPTY);
    end

    always_comb
    begin
        pos_next = pos_reg;
        dig_next = dig_reg;
        if (conv_take)
        begin
            pos_next = '0;
            dig_next = conv.bcd;
        end
        else if (state_reg == EM_RUN && adv)
        begin
            pos_next = pos_reg + CNT_W'(1);
            if (in_digits)
            begin
                dig_next = {dig_reg[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
            end
        end
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= EM_IDLE;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dig_reg <= dig_next;
        if (conv_take)
        begin
            b1_reg    <= CNT_W'(b1_c);
            b2_reg    <= CNT_W'(b2_c);
            b3_reg    <= CNT_W'(b3_c);
            b4_reg    <= CNT_W'(b4_c);
            total_reg <= CNT_W'(total_c);
            sign_reg  <= sign_c;
        end
        if (out_load)
        begin
            out_char_reg  <= (state_reg == EM_EMPTY) ? CHAR_NUL : char_c;
            out_last_reg  <= (state_reg == EM_EMPTY) ? 1'b1 : last_c;
            out_empty_reg <= (state_reg == EM_EMPTY);
        end
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.character = out_char_reg;
    assign out_ch.is_last   = out_last_reg;
    assign out_ch.empty_res = out_empty_reg;

    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_empty_reg) |-> (out_last_reg && out_char_reg == CHAR_NUL))
        else $error("empty item not marked last");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == EM_RUN |-> pos_reg < total_reg)
        else $error("position past end of text");

    a_take_starts: assert property (@(posedge clk) disable iff (!rst_n)
        conv_take |=> (state_reg == EM_RUN || state_reg == EM_EMPTY))
        else $error("taken item not emitted");

endmodule

// File: rtl/core/signed_decimal_formatter_unit.sv
// signed_decimal_formatter_unit: top level of the printf %d formatter
// depends on sdf_pkg, sdf_channels, sdf_bcd_conv and sdf_emitter

// Formats one signed 32-bit value per input item as printf %d text and sends it out one
// ASCII character per output item, with is_last on the final character; a text of no
// characters comes out as a single item with empty_res and is_last set. Field width is
// clamped to MAX_WIDTH and precision to MAX_PRECISION; any negative precision means none.
// After the item is accepted, the bit-serial bcd converter shifts in the magnitude, one bit
// per cycle, then drops leading zero digits, one digit per cycle, and then holds the digits
// until the emitter is idle and takes them. The emitter then sends one character per cycle,
// as many characters as the text is long (up to max(MAX_WIDTH, MAX_PRECISION + 1, 11)),
// slowed only by output back-pressure. Conversion of the next item overlaps emission of the
// current one. Input ready is high whenever the converter is free.
module signed_decimal_formatter_unit #(
    parameter int MAX_WIDTH     = 32,
    parameter int MAX_PRECISION = 30
) (
    input  logic      clk,
    input  logic      rst_n,
    sdf_in_if.sink    in_ch,
    sdf_out_if.source out_ch
);
    import sdf_pkg::*;

    // converted magnitude, digit count, sign and format flags
    sdf_conv_t conv;
    logic      conv_valid;
    logic      conv_take;

    // bit-serial shift-add-3 conversion
    sdf_bcd_conv u_conv (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .conv       (conv),
        .conv_valid (conv_valid),
        .conv_take  (conv_take)
    );

    // layout and one-character-per-cycle output unless stalled, with its own output register
    sdf_emitter #(
        .MAX_WIDTH     (MAX_WIDTH),
        .MAX_PRECISION (MAX_PRECISION)
    ) u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .conv       (conv),
        .conv_valid (conv_valid),
        .conv_take  (conv_take),
        .out_ch     (out_ch)
    );

endmodule

// File: tb/sv/signed_decimal_formatter_unit_tb.sv
// signed_decimal_formatter_unit_tb: self-checking bench for the printf %d formatter
// predicts the text of every accepted number and checks it character by character
// depends on sdf_pkg, sdf_channels and signed_decimal_formatter_unit

module signed_decimal_formatter_unit_tb;
    import sdf_pkg::*;

    localparam int TXT_MAX_WIDTH     = 32;
    localparam int TXT_MAX_PRECISION = 30;
    localparam int RANDOM_NUMBERS    = 470;
    localparam int HOLD_CYCLES       = 400;   // long receiver hold-off, fills the block
    localparam int DRAIN_CYCLES      = 64;    // drain wait, longer than a full conversion
    localparam int WATCHDOG_LIMIT    = 4000;  // hold-off plus conversion, several times over
    localparam int REPORT_LIMIT      = 10;

    localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [PREC_W-1:0]  NO_PREC   = -6'sd1;

    // one number with its format flags, as offered on the input channel
    typedef struct {
        logic signed [VALUE_W-1:0] value;
        sdf_fmt_t                  fmt;
    } num_item_t;

    // one character of formatted text, as seen on the output channel
    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              is_last;
        logic              empty_res;
    } char_item_t;

    logic clk = 1'b0;
    logic rst_n;

    sdf_in_if  num_ch ();
    sdf_out_if txt_ch ();

    signed_decimal_formatter_unit #(
        .MAX_WIDTH     (TXT_MAX_WIDTH),
        .MAX_PRECISION (TXT_MAX_PRECISION)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (num_ch),
        .out_ch (txt_ch)
    );

    always #5 clk = ~clk;

    num_item_t  pending_numbers[$];   // numbers not yet offered
    char_item_t expected_text[$];     // predicted characters, oldest first
    num_item_t  offered_number;       // number currently on the input channel
    int         numbers_taken;
    int         mismatches;
    int         hold_left;
    int         hold_count;
    int         idle_cycles;
    logic       hold_off;

    // printf %d formatting of one number, appended to expected_text
    function automatic void format_decimal(input num_item_t it);
        logic [VALUE_W-1:0] mag;
        logic               neg;
        logic               has_prec;
        int unsigned        width;
        int unsigned        prec;
        int unsigned        ndig;
        int unsigned        nsign;
        int unsigned        lead_zeros;
        int unsigned        pad;
        int unsigned        body;
        logic [CHAR_W-1:0]  sign_ch;
        logic [CHAR_W-1:0]  text[$];
        logic [3:0]         digit_buf[DIGITS];
        char_item_t         entry;

        // the most negative value wraps to 2^31, which is its true magnitude
        neg = it.value[VALUE_W-1];
        mag = neg ? -it.value : it.value;

        width = it.fmt.field_width;
        if (width > TXT_MAX_WIDTH)
        begin
            width = TXT_MAX_WIDTH;
        end
        // any negative precision means none was given
        has_prec = !it.fmt.precision[PREC_W-1];
        prec     = has_prec ? int'(it.fmt.precision) : 0;
        if (prec > TXT_MAX_PRECISION)
        begin
            prec = TXT_MAX_PRECISION;
        end

        // zero with precision zero prints no digits at all
        ndig = 0;
        if (!(has_prec && prec == 0 && mag == 0))
        begin
            do
            begin
                digit_buf[ndig] = 4'(mag % 10);
                ndig++;
                mag = mag / 10;
            end while (mag != 0);
        end

        if (neg)
            sign_ch = CHAR_MINUS;
        else if (it.fmt.force_plus)
            sign_ch = CHAR_PLUS;
        else if (it.fmt.space_sign)
            sign_ch = CHAR_SPACE;
        else
            sign_ch = CHAR_NUL;
        nsign = (sign_ch != CHAR_NUL) ? 1 : 0;

        lead_zeros = (has_prec && prec > ndig) ? prec - ndig : 0;
        body       = ndig + nsign;
        // zero fill only without precision and right-justified
        if (!has_prec && !it.fmt.left_justify && it.fmt.zero_pad && width > body)
        begin
            lead_zeros = width - body;
        end
        pad = (width > body + lead_zeros) ? width - body - lead_zeros : 0;

        // empty text comes out as one marked item
        if (body + lead_zeros + pad == 0)
        begin
            entry.character = CHAR_NUL;
            entry.is_last   = 1'b1;
            entry.empty_res = 1'b1;
            expected_text.push_back(entry);
            return;
        end

        if (!it.fmt.left_justify)
            repeat (pad) text.push_back(CHAR_SPACE);
        if (nsign != 0)
            text.push_back(sign_ch);
        repeat (lead_zeros) text.push_back(CHAR_ZERO);
        for (int i = ndig; i > 0; i--)
        begin
            text.push_back(CHAR_W'(CHAR_ZERO + digit_buf[i-1]));
        end
        if (it.fmt.left_justify)
            repeat (pad) text.push_back(CHAR_SPACE);

        foreach (text[i])
        begin
            entry.character = text[i];
            entry.is_last   = (i == text.size() - 1);
            entry.empty_res = 1'b0;
            expected_text.push_back(entry);
        end
    endfunction

    function automatic void queue_number(
        input logic signed [VALUE_W-1:0] value,
        input logic [FW_W-1:0]           field_width,
        input logic signed [PREC_W-1:0]  precision,
        input logic                      left_justify,
        input logic                      zero_pad,
        input logic                      force_plus,
        input logic                      space_sign
    );
        num_item_t it;
        it.value             = value;
        it.fmt.field_width   = field_width;
        it.fmt.precision     = precision;
        it.fmt.left_justify  = left_justify;
        it.fmt.zero_pad      = zero_pad;
        it.fmt.force_plus    = force_plus;
        it.fmt.space_sign    = space_sign;
        pending_numbers.push_back(it);
    endfunction

    // sender: bursts of numbers with random gaps, held stable until taken
    int burst_left;
    int gap_left;

    always @(posedge clk or negedge rst_n)
    begin : sender
        logic taken;
        if (!rst_n)
        begin
            num_ch.valid        <= 1'b0;
            num_ch.value        <= '0;
            num_ch.field_width  <= '0;
            num_ch.precision    <= '0;
            num_ch.left_justify <= 1'b0;
            num_ch.zero_pad     <= 1'b0;
            num_ch.force_plus   <= 1'b0;
            num_ch.space_sign   <= 1'b0;
            numbers_taken       <= 0;
            burst_left = 1;
            gap_left   = 0;
        end
        else
        begin
            taken = num_ch.valid && num_ch.ready;
            if (taken)
            begin
                format_decimal(offered_number);
                numbers_taken <= numbers_taken + 1;
            end

            if (num_ch.valid && !taken)
            begin
                // keep offering the same number
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                num_ch.valid <= 1'b0;
            end
            else if (pending_numbers.size() != 0)
            begin
                offered_number = pending_numbers.pop_front();
                num_ch.valid        <= 1'b1;
                num_ch.value        <= offered_number.value;
                num_ch.field_width  <= offered_number.fmt.field_width;
                num_ch.precision    <= offered_number.fmt.precision;
                num_ch.left_justify <= offered_number.fmt.left_justify;
                num_ch.zero_pad     <= offered_number.fmt.zero_pad;
                num_ch.force_plus   <= offered_number.fmt.force_plus;
                num_ch.space_sign   <= offered_number.fmt.space_sign;
                if (burst_left <= 1)
                begin
                    // a quarter of the bursts run straight into the next one
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
                end
                else
                begin
                    burst_left--;
                end
            end
            else
            begin
                num_ch.valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off, twice in the run, while the sender keeps offering
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left  <= 0;
            hold_count <= 0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
        else if (hold_count < 2 && numbers_taken >= ((hold_count == 0) ? 60 : 300))
        begin
            hold_left  <= HOLD_CYCLES;
            hold_count <= hold_count + 1;
        end
    end

    assign hold_off = (hold_left != 0);

    // receiver: checks each taken character, stalls on a changing pattern
    int stall_mode;
    int mode_left;
    int stall_period;
    int stall_low;
    int stall_phase;
    int chars_seen;

    always @(posedge clk or negedge rst_n)
    begin : receiver
        char_item_t want;
        logic       open;
        if (!rst_n)
        begin
            txt_ch.ready <= 1'b0;
            mismatches   = 0;
            chars_seen   = 0;
            mode_left    = 0;
            stall_phase  = 0;
        end
        else
        begin
            if (txt_ch.valid && txt_ch.ready)
            begin
                if (expected_text.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("unexpected character %02h last %0b empty %0b at item %0d",
                                 txt_ch.character, txt_ch.is_last, txt_ch.empty_res,
                                 chars_seen);
                end
                else
                begin
                    want = expected_text.pop_front();
                    // character carries no meaning on an empty text
                    if (txt_ch.is_last !== want.is_last ||
                        txt_ch.empty_res !== want.empty_res ||
                        (!want.empty_res && txt_ch.character !== want.character))
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display("item %0d: want %02h/%0b/%0b got %02h/%0b/%0b",
                                     chars_seen, want.character, want.is_last, want.empty_res,
                                     txt_ch.character, txt_ch.is_last, txt_ch.empty_res);
                    end
                end
                chars_seen++;
            end

            // pick a new stall pattern when the current one runs out
            if (mode_left == 0)
            begin
                stall_mode   = $urandom_range(0, 2);
                mode_left    = $urandom_range(20, 200);
                stall_period = $urandom_range(2, 12);
                stall_low    = $urandom_range(1, stall_period - 1);
                stall_phase  = 0;
            end
            else
            begin
                mode_left--;
            end
            stall_phase = (stall_phase + 1) % stall_period;

            case (stall_mode)
                0:       open = 1'b1;
                1:       open = ($urandom_range(0, 3) != 0);
                default: open = (stall_phase >= stall_low);
            endcase
            txt_ch.ready <= open && !hold_off;
        end
    end

    // watchdog: too long with neither channel moving
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((num_ch.valid && num_ch.ready) || (txt_ch.valid && txt_ch.ready))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
        else
        begin
            idle_cycles <= 0;
        end
    end

    initial
    begin
        logic signed [VALUE_W-1:0] v;
        logic [FW_W-1:0]           w;
        logic signed [PREC_W-1:0]  p;

        // known levels before the first edge
        num_ch.valid        = 1'b0;
        num_ch.value        = '0;
        num_ch.field_width  = '0;
        num_ch.precision    = '0;
        num_ch.left_justify = 1'b0;
        num_ch.zero_pad     = 1'b0;
        num_ch.force_plus   = 1'b0;
        num_ch.space_sign   = 1'b0;
        txt_ch.ready        = 1'b0;
        rst_n               = 1'b0;

        // directed: field extremes, sign rules, padding rules, clamps
        queue_number(0, 0, NO_PREC, 0, 0, 0, 0);            // plain zero
        queue_number(0, 0, 0, 0, 0, 0, 0);                  // empty text
        queue_number(0, 5, 0, 0, 0, 0, 0);                  // no digits, only padding
        queue_number(0, 0, 0, 0, 0, 1, 0);                  // no digits, plus sign alone
        queue_number(0, 0, 0, 0, 0, 0, 1);                  // no digits, space sign alone
        queue_number(0, 0, 0, 1, 1, 1, 1);                  // all flags on zero
        queue_number(VALUE_MIN, 0, NO_PREC, 0, 0, 0, 0);    // most negative value
        queue_number(VALUE_MAX, 0, NO_PREC, 0, 0, 1, 0);
        queue_number(-1, 10, NO_PREC, 0, 1, 0, 0);          // zero fill after sign
        queue_number(42, 10, NO_PREC, 1, 1, 0, 0);          // left-justify beats zero fill
        queue_number(42, 10, 5, 0, 1, 0, 0);                // precision beats zero fill
        queue_number(-7, 63, NO_PREC, 0, 0, 0, 0);          // width above the clamp
        queue_number(7, 0, 6'sd31, 0, 0, 0, 0);             // precision above the clamp
        queue_number(123, 8, -6'sd32, 0, 1, 0, 0);          // most negative precision
        queue_number(VALUE_MIN, 32, 6'sd30, 1, 0, 0, 0);
        queue_number(5, 1, 6'sd30, 0, 0, 1, 1);             // longest precision text
        queue_number(1, 32, NO_PREC, 0, 1, 0, 1);           // space sign, zero filled
        queue_number(VALUE_MIN + 1, 12, 6'sd11, 0, 0, 0, 0);
        queue_number(99, 3, 6'sd2, 1, 0, 1, 1);
        queue_number(VALUE_MAX, 63, -6'sd5, 1, 0, 0, 1);

        // random: values of every size, widths and precisions up to and above the clamps
        for (int n = 0; n < RANDOM_NUMBERS; n++)
        begin
            case ($urandom_range(0, 5))
                0: v = $urandom_range(0, 9);
                1: v = $urandom_range(0, 99999);
                2: v = -$signed($urandom_range(0, 1000));
                3:
                begin
                    case ($urandom_range(0, 5))
                        0:       v = 0;
                        1:       v = -1;
                        2:       v = VALUE_MIN;
                        3:       v = VALUE_MAX;
                        4:       v = VALUE_MIN + 1;
                        default: v = 1;
                    endcase
                end
                default: v = $urandom;
            endcase
            w = ($urandom_range(0, 7) == 0) ? FW_W'($urandom_range(0, 63))
                                            : FW_W'($urandom_range(0, 34));
            case ($urandom_range(0, 3))
                0:       p = NO_PREC;
                1:       p = PREC_W'($urandom_range(0, 12));
                default: p = PREC_W'($urandom_range(0, 63));
            endcase
            queue_number(v, w, p, $urandom_range(0, 1), $urandom_range(0, 1),
                         $urandom_range(0, 1), $urandom_range(0, 1));
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // every number taken and every character back
        while (pending_numbers.size() != 0 || num_ch.valid || expected_text.size() != 0)
            @(negedge clk);
        // stray characters after the last one would still be caught here
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatches == 0 && expected_text.size() == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/core/sdf_pkg.sv
rtl/core/sdf_channels.sv
rtl/core/sdf_bcd_conv.sv
rtl/core/sdf_emitter.sv
rtl/core/signed_decimal_formatter_unit.sv
tb/sv/signed_decimal_formatter_unit_tb.sv
